// File: sv/sort_and_merge_source_tags_unit_assert.svh
// Assertion macros for the checker file of the sort-and-merge tagger.
// Needs a clk and an active-low rst_n in the scope where they are used.
`ifndef SORT_AND_MERGE_SOURCE_TAGS_UNIT_ASSERT_SVH
`define SORT_AND_MERGE_SOURCE_TAGS_UNIT_ASSERT_SVH

// checked only outside reset
`define SMST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SMST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/smst_pkg.sv
// Package for the sort-and-merge tagger: widths, input codes, queue word types.
// No dependencies; used by every module of the block.
`default_nettype none
package smst_pkg;

  localparam int VALUE_W        = 32;
  localparam int FUNC_W         = 2;
  localparam int LIST_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int OUT_DATA_W     = 8;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH_A,
    OP_PUSH_B,
    OP_RUN
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage
`default_nettype wire

// File: sv/smst_sort_list.sv
// One list kept in ascending order by a row of insertion cells.
// Depends on smst_pkg for the value width.
`default_nettype none
module smst_sort_list #(
  parameter int DEPTH = smst_pkg::LIST_DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               ins_en,
  input  logic signed [smst_pkg::VALUE_W-1:0] ins_value,
  input  logic                               pop_en,
  output logic signed [smst_pkg::VALUE_W-1:0] head_value,
  output logic [CNT_W-1:0]                   count
);

  logic signed [smst_pkg::VALUE_W-1:0] val_r   [DEPTH];
  logic signed [smst_pkg::VALUE_W-1:0] val_nxt [DEPTH];
  logic [DEPTH-1:0]                    valid_r, valid_nxt;
  logic [DEPTH-1:0]                    le;
  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic                                do_ins;

  // a push into a full list is dropped
  assign do_ins = ins_en && (count_r != CNT_W'(DEPTH));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = valid_r[i] && (val_r[i] <= ins_value);
    end
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (do_ins) begin
      // new value goes in after every cell that holds a smaller or equal one
      if (!le[0]) val_nxt[0] = ins_value;
      valid_nxt[0] = 1'b1;
      for (int i = 1; i < DEPTH; i++) begin
        if (!le[i]) val_nxt[i] = le[i-1] ? ins_value : val_r[i-1];
        valid_nxt[i] = valid_r[i] | valid_r[i-1];
      end
    end else if (pop_en) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        val_nxt[i]   = val_r[i+1];
        valid_nxt[i] = valid_r[i+1];
      end
      valid_nxt[DEPTH-1] = 1'b0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins)                          count_nxt = count_r + CNT_W'(1);
    else if (pop_en && count_r != '0)    count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign head_value = val_r[0];
  assign count      = count_r;

endmodule
`default_nettype wire

// File: sv/smst_front.sv
// Front end: takes input words, decodes the function code, queues commands.
// Depends on smst_pkg for codes and the queue word type.
`default_nettype none
module smst_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [smst_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [smst_pkg::VALUE_W-1:0] in_value,
  output smst_pkg::q_head_t                  head,
  input  logic                               head_pop
);

  localparam int QD    = smst_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(QD);

  smst_pkg::cmd_t          q_mem_r [QD];
  logic [PTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]          fill_r, fill_nxt;
  logic                    dec_valid;
  smst_pkg::op_t           dec_op;
  logic                    wr_en;

  always_comb begin
    dec_valid = 1'b1;
    dec_op    = smst_pkg::OP_PUSH_A;
    unique case (in_func)
      smst_pkg::FUNC_PUSH_A: dec_op = smst_pkg::OP_PUSH_A;
      smst_pkg::FUNC_PUSH_B: dec_op = smst_pkg::OP_PUSH_B;
      smst_pkg::FUNC_RUN:    dec_op = smst_pkg::OP_RUN;
      default:               dec_valid = 1'b0;   // unused code: swallowed
    endcase
  end

  assign in_ready = (fill_r != (PTR_W+1)'(QD));
  assign wr_en    = in_valid && in_ready && dec_valid;

  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && !head_pop)      fill_nxt = fill_r + (PTR_W+1)'(1);
    else if (!wr_en && head_pop) fill_nxt = fill_r - (PTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (wr_en)    wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (head_pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem_r[wr_ptr_r].op    <= dec_op;
      q_mem_r[wr_ptr_r].value <= in_value;
    end
  end

  assign head.valid = (fill_r != '0);
  assign head.cmd   = q_mem_r[rd_ptr_r];

endmodule
`default_nettype wire

// File: sv/smst_back.sv
// Back end: executes queued pushes and runs, merges the two sorted lists.
// Depends on smst_pkg and smst_sort_list.
`default_nettype none
module smst_back #(
  parameter int LIST_DEPTH = smst_pkg::LIST_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  smst_pkg::q_head_t head,
  output logic              head_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_from_b,
  output logic              out_last
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  logic signed [smst_pkg::VALUE_W-1:0] a_head, b_head;
  logic [CNT_W-1:0]                    cnt_a, cnt_b;
  logic [CNT_W:0]                      remain;
  logic ins_a, ins_b, pop_a, pop_b;
  logic is_run, lists_empty, slot_free, emit, take_a;
  logic out_valid_r, out_valid_nxt, out_from_b_r, out_last_r;

  smst_sort_list #(.DEPTH(LIST_DEPTH), .CNT_W(CNT_W)) u_list_a (
    .clk, .rst_n,
    .ins_en(ins_a), .ins_value(head.cmd.value), .pop_en(pop_a),
    .head_value(a_head), .count(cnt_a)
  );

  smst_sort_list #(.DEPTH(LIST_DEPTH), .CNT_W(CNT_W)) u_list_b (
    .clk, .rst_n,
    .ins_en(ins_b), .ins_value(head.cmd.value), .pop_en(pop_b),
    .head_value(b_head), .count(cnt_b)
  );

  assign remain      = {1'b0, cnt_a} + {1'b0, cnt_b};
  assign lists_empty = (remain == '0);
  assign is_run      = head.valid && (head.cmd.op == smst_pkg::OP_RUN);
  assign slot_free   = !out_valid_r || out_ready;
  assign emit        = is_run && !lists_empty && slot_free;
  // ties go to list A
  assign take_a      = (cnt_a != '0) && ((cnt_b == '0) || (a_head <= b_head));

  assign ins_a    = head.valid && (head.cmd.op == smst_pkg::OP_PUSH_A);
  assign ins_b    = head.valid && (head.cmd.op == smst_pkg::OP_PUSH_B);
  assign pop_a    = emit && take_a;
  assign pop_b    = emit && !take_a;
  assign head_pop = ins_a || ins_b || (is_run && lists_empty);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_from_b_r <= !take_a;
      out_last_r   <= (remain == (CNT_W+1)'(1));
    end
  end

  assign out_valid  = out_valid_r;
  assign out_from_b = out_from_b_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

// File: sv/sort_and_merge_source_tags_unit.sv
// Sort-and-merge source tagger. Words on the input stream push signed 32-bit
// values into list A (tuser = 0) or list B (tuser = 1), or start a run
// (tuser = 2); tuser = 3 is accepted and ignored. Each list sorts itself on
// insertion, and a push to a full list (LIST_DEPTH entries) is dropped. A run
// merges the two sorted lists and sends one output word per element: tdata
// bit 0 says whether it came from list B, tlast marks the final word. Equal
// values take A first, and the run leaves both lists empty; a run on two
// empty lists sends nothing. Rate: a run holds the back end until both lists
// are empty; with an output that takes every word it sends one word a cycle,
// set by the single compare of the two list heads, then retires the run. A
// two-entry command queue sits between the input decoder and the execution
// side. The output register holds each word until it is taken; the merge
// waits behind it, and the next word moves in on the cycle it leaves.
// Depends on smst_pkg, smst_front, smst_back, smst_sort_list.
`default_nettype none
module sort_and_merge_source_tags_unit #(
  parameter int LIST_DEPTH = smst_pkg::LIST_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [smst_pkg::VALUE_W-1:0]      in_tdata,   // [31:0] value (signed)
  input  logic [smst_pkg::FUNC_W-1:0]       in_tuser,   // [1:0] func
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [smst_pkg::OUT_DATA_W-1:0]   out_tdata,  // [0] from_b, [7:1] zero
  output logic                              out_tlast
);

  smst_pkg::q_head_t q_head;
  logic              q_pop;
  logic              from_b;

  // decode and queue
  smst_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_func(in_tuser), .in_value($signed(in_tdata)),
    .head(q_head), .head_pop(q_pop)
  );

  // list storage, merge and output register
  smst_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk, .rst_n,
    .head(q_head), .head_pop(q_pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_from_b(from_b), .out_last(out_tlast)
  );

  assign out_tdata = {{(smst_pkg::OUT_DATA_W-1){1'b0}}, from_b};

endmodule
`default_nettype wire

// File: sv/smst_checker.sv
// Port-level checks for the sort-and-merge tagger, bound to the top level.
// Depends on sort_and_merge_source_tags_unit_assert.svh and smst_pkg.
`default_nettype none
`include "sort_and_merge_source_tags_unit_assert.svh"
module smst_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [smst_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  // output word holds while stalled
  `SMST_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output word changed while stalled")
  // nothing leaves straight out of reset
  `SMST_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "output valid after reset")
  // padding bits of the output word stay clear
  `SMST_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[smst_pkg::OUT_DATA_W-1:1] == '0, "output padding not zero")
  // an empty queue after reset takes the first word
  `SMST_ASSERT(a_ready_after_reset, $rose(rst_n) |-> in_tready, "input not ready after reset")

endmodule

bind sort_and_merge_source_tags_unit smst_checker u_smst_checker (.*);
`default_nettype wire
